FILE: design/ocv2soc_pkg.sv
// Shared constants, breakpoint table and control types for the OCV to SoC interpolator.
package ocv2soc_pkg;

   localparam int VOLT_W        = 13;
   localparam int SOC_W         = 10;
   localparam int PROD_W        = VOLT_W + SOC_W;
   localparam int CNT_W         = $clog2(PROD_W);
   localparam int STORED_POINTS = 201;
   localparam int STORED_IDX_W  = $clog2(STORED_POINTS);
   localparam int TABLE_POINTS_DEF = 201;
   localparam int MIN_POINTS    = 2;
   localparam int SOC_FULL      = 1000;

   localparam logic [VOLT_W-1:0] VOLT_BREAKS [STORED_POINTS] = '{
      13'd2925, 13'd2985, 13'd3062, 13'd3121, 13'd3173, 13'd3219, 13'd3259, 13'd3296,
      13'd3329, 13'd3359, 13'd3387, 13'd3412, 13'd3436, 13'd3458, 13'd3479, 13'd3498,
      13'd3516, 13'd3533, 13'd3549, 13'd3563, 13'd3575, 13'd3583, 13'd3586, 13'd3589,
      13'd3591, 13'd3593, 13'd3596, 13'd3598, 13'd3601, 13'd3603, 13'd3606, 13'd3609,
      13'd3612, 13'd3616, 13'd3619, 13'd3623, 13'd3627, 13'd3632, 13'd3637, 13'd3642,
      13'd3648, 13'd3654, 13'd3660, 13'd3666, 13'd3672, 13'd3678, 13'd3684, 13'd3690,
      13'd3696, 13'd3702, 13'd3709, 13'd3716, 13'd3722, 13'd3728, 13'd3734, 13'd3740,
      13'd3746, 13'd3753, 13'd3760, 13'd3767, 13'd3774, 13'd3781, 13'd3787, 13'd3792,
      13'd3796, 13'd3801, 13'd3805, 13'd3810, 13'd3814, 13'd3818, 13'd3822, 13'd3826,
      13'd3829, 13'd3833, 13'd3836, 13'd3840, 13'd3843, 13'd3847, 13'd3850, 13'd3853,
      13'd3856, 13'd3859, 13'd3862, 13'd3865, 13'd3868, 13'd3870, 13'd3873, 13'd3876,
      13'd3878, 13'd3881, 13'd3883, 13'd3886, 13'd3888, 13'd3890, 13'd3893, 13'd3895,
      13'd3898, 13'd3900, 13'd3902, 13'd3905, 13'd3907, 13'd3909, 13'd3911, 13'd3913,
      13'd3916, 13'd3918, 13'd3920, 13'd3922, 13'd3924, 13'd3926, 13'd3928, 13'd3930,
      13'd3933, 13'd3935, 13'd3937, 13'd3939, 13'd3941, 13'd3944, 13'd3946, 13'd3948,
      13'd3951, 13'd3953, 13'd3955, 13'd3958, 13'd3960, 13'd3963, 13'd3966, 13'd3969,
      13'd3971, 13'd3974, 13'd3978, 13'd3981, 13'd3985, 13'd3989, 13'd3993, 13'd3997,
      13'd4002, 13'd4006, 13'd4011, 13'd4015, 13'd4020, 13'd4024, 13'd4029, 13'd4033,
      13'd4036, 13'd4040, 13'd4044, 13'd4047, 13'd4050, 13'd4053, 13'd4056, 13'd4059,
      13'd4061, 13'd4064, 13'd4066, 13'd4068, 13'd4071, 13'd4073, 13'd4075, 13'd4077,
      13'd4079, 13'd4080, 13'd4082, 13'd4084, 13'd4085, 13'd4087, 13'd4089, 13'd4090,
      13'd4092, 13'd4093, 13'd4095, 13'd4096, 13'd4098, 13'd4100, 13'd4102, 13'd4103,
      13'd4105, 13'd4107, 13'd4109, 13'd4111, 13'd4113, 13'd4115, 13'd4117, 13'd4120,
      13'd4122, 13'd4125, 13'd4128, 13'd4131, 13'd4134, 13'd4137, 13'd4141, 13'd4144,
      13'd4148, 13'd4153, 13'd4158, 13'd4163, 13'd4168, 13'd4174, 13'd4181, 13'd4188,
      13'd4199
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_MULT,
      ST_DIVIDE,
      ST_DONE
   } ocv2soc_state_type;

   typedef struct packed {
      logic             load;
      logic             search;
      logic             fetch;
      logic             mult;
      logic             div_step;
      logic             finish;
      logic [CNT_W-1:0] step;
   } ocv2soc_cmd_type;

   typedef struct packed {
      logic direct;
   } ocv2soc_status_type;

   // Clamp the requested point count to at least MIN_POINTS and at most what the stored table holds.
   function automatic int points_used(input int requested);
      int n;
      n = requested;
      if (n < MIN_POINTS) n = MIN_POINTS;
      if (n > STORED_POINTS) n = STORED_POINTS;
      return n;
   endfunction

endpackage

FILE: design/ocv_to_soc_interpolator.sv
// Open-circuit voltage to state-of-charge interpolator, top level.
// Voltages outside the table go straight to the result; others take clog2(points)
// search steps, a segment fetch, the multiply and the divide. A new voltage is
// taken only while the sequencer is idle; the 23-step restoring divider and the
// one-bit-per-cycle breakpoint search set the pace. The result register frees the
// sequencer once loaded. Reset clears the sequencer state and the result valid.
module ocv_to_soc_interpolator #(
   parameter int TABLE_POINTS = ocv2soc_pkg::TABLE_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ocv2soc_pkg::VOLT_W-1:0] req_ocv_mv,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ocv2soc_pkg::SOC_W-1:0]  rsp_soc_tenths
);
   import ocv2soc_pkg::*;

   ocv2soc_cmd_type    cmd;
   ocv2soc_status_type status;

   ocv2soc_ctrl #(
      .TABLE_POINTS(TABLE_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ocv2soc_datapath #(
      .TABLE_POINTS(TABLE_POINTS)
   ) u_datapath (
      .clock          (clock),
      .req_ocv_mv     (req_ocv_mv),
      .cmd            (cmd),
      .status         (status),
      .rsp_soc_tenths (rsp_soc_tenths)
   );

endmodule

FILE: design/ocv2soc_ctrl.sv
// Sequencer for breakpoint search, multiply and serial divide, plus result valid.
module ocv2soc_ctrl #(
   parameter int TABLE_POINTS = ocv2soc_pkg::TABLE_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ocv2soc_pkg::ocv2soc_cmd_type    cmd,
   input  ocv2soc_pkg::ocv2soc_status_type status
);
   import ocv2soc_pkg::*;

   localparam int POINTS_USED = points_used(TABLE_POINTS);
   localparam int IDX_W       = $clog2(POINTS_USED);

   ocv2soc_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.step = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(IDX_W - 1);
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.direct) begin
               state_in = ST_DONE;
            end else begin
               cmd.search = 1'b1;
               if (cnt_ff == '0) state_in = ST_FETCH;
               else cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            cnt_in   = CNT_W'(PROD_W - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) state_in = ST_DONE;
            else cnt_in = cnt_ff - 1'b1;
         end
         ST_DONE: begin
            // wait until the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/ocv2soc_datapath.sv
// Breakpoint search, segment fetch, product and restoring divider for the interpolation.
module ocv2soc_datapath #(
   parameter int TABLE_POINTS = ocv2soc_pkg::TABLE_POINTS_DEF
) (
   input  logic                              clock,
   input  logic [ocv2soc_pkg::VOLT_W-1:0]    req_ocv_mv,
   input  ocv2soc_pkg::ocv2soc_cmd_type      cmd,
   output ocv2soc_pkg::ocv2soc_status_type   status,
   output logic [ocv2soc_pkg::SOC_W-1:0]     rsp_soc_tenths
);
   import ocv2soc_pkg::*;

   localparam int POINTS_USED = points_used(TABLE_POINTS);
   localparam int IDX_W       = $clog2(POINTS_USED);
   localparam int SUM_W       = PROD_W + 1;

   // charge points, worked out at elaboration
   logic [SOC_W-1:0] charge_pts [POINTS_USED];

   for (genvar g = 0; g < POINTS_USED; g++) begin : g_charge
      localparam int CHARGE = (g * SOC_FULL) / (POINTS_USED - 1);
      assign charge_pts[g] = SOC_W'(CHARGE);
   end

   logic [VOLT_W-1:0] volt_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              direct_ff, direct_in;
   logic [SOC_W-1:0]  direct_val_ff, direct_val_in;
   logic [VOLT_W-1:0] diff_v_ff, span_ff;
   logic [SOC_W-1:0]  diff_c_ff, lo_c_ff;
   logic              empty_ff;
   logic [VOLT_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] num_ff, num_in;
   logic [SOC_W-1:0]  rsp_soc_tenths_ff, rsp_soc_tenths_in;

   logic [IDX_W-1:0]  cand;
   logic [IDX_W-1:0]  idx_hi;
   logic [VOLT_W-1:0] lo_v, hi_v;
   logic [VOLT_W:0]   rem_sh;
   logic              q_bit;
   logic [SUM_W-1:0]  sum;

   // Entry or direct outcome
   always_comb begin
      direct_in     = direct_ff;
      direct_val_in = direct_val_ff;
      if (cmd.load) begin
         direct_in     = 1'b0;
         direct_val_in = '0;
         if (req_ocv_mv < VOLT_BREAKS[0]) begin
            direct_in = 1'b1;
         end else if (req_ocv_mv >= VOLT_BREAKS[POINTS_USED-1]) begin
            direct_in     = 1'b1;
            direct_val_in = SOC_W'(SOC_FULL);
         end
      end
   end

   // One index bit per search step, highest first
   always_comb begin
      cand   = idx_ff | (IDX_W'(1) << cmd.step);
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.search) begin
         if (cand <= IDX_W'(POINTS_USED - 2) &&
             VOLT_BREAKS[STORED_IDX_W'(cand)] <= volt_ff) begin
            idx_in = cand;
         end
      end
   end

   assign idx_hi = idx_ff + IDX_W'(1);
   assign lo_v   = VOLT_BREAKS[STORED_IDX_W'(idx_ff)];
   assign hi_v   = VOLT_BREAKS[STORED_IDX_W'(idx_hi)];

   // Restoring divide step
   always_comb begin
      rem_sh = {rem_ff, num_ff[PROD_W-1]};
      q_bit  = (rem_sh >= {1'b0, span_ff});
      rem_in = rem_ff;
      num_in = num_ff;
      if (cmd.mult) begin
         rem_in = '0;
         num_in = PROD_W'(diff_v_ff) * PROD_W'(diff_c_ff);
      end else if (cmd.div_step) begin
         rem_in = q_bit ? VOLT_W'(rem_sh - {1'b0, span_ff}) : VOLT_W'(rem_sh);
         num_in = {num_ff[PROD_W-2:0], q_bit};
      end
   end

   always_comb begin
      sum               = SUM_W'(lo_c_ff) + SUM_W'(num_ff);
      rsp_soc_tenths_in = rsp_soc_tenths_ff;
      if (cmd.finish) begin
         priority if (direct_ff) begin
            rsp_soc_tenths_in = direct_val_ff;
         end else if (empty_ff) begin
            rsp_soc_tenths_in = lo_c_ff;
         end else if (sum > SUM_W'(SOC_FULL)) begin
            rsp_soc_tenths_in = SOC_W'(SOC_FULL);
         end else begin
            rsp_soc_tenths_in = SOC_W'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) volt_ff <= req_ocv_mv;
      idx_ff            <= idx_in;
      direct_ff         <= direct_in;
      direct_val_ff     <= direct_val_in;
      rem_ff            <= rem_in;
      num_ff            <= num_in;
      rsp_soc_tenths_ff <= rsp_soc_tenths_in;
      if (cmd.fetch) begin
         diff_v_ff <= volt_ff - lo_v;
         span_ff   <= hi_v - lo_v;
         diff_c_ff <= charge_pts[idx_hi] - charge_pts[idx_ff];
         lo_c_ff   <= charge_pts[idx_ff];
         empty_ff  <= (hi_v <= lo_v) || (volt_ff < lo_v);
      end
   end

   assign status.direct  = direct_ff;
   assign rsp_soc_tenths = rsp_soc_tenths_ff;

endmodule

FILE: tb/sv/tb_ocv_to_soc_interpolator.sv
// Self-checking testbench for the cell voltage to state-of-charge interpolator.
module tb_ocv_to_soc_interpolator;

   import ocv2soc_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 4;
   localparam int SPAN_POINTS   = (TABLE_POINTS_DEF < MIN_POINTS) ? MIN_POINTS :
                                  (TABLE_POINTS_DEF > STORED_POINTS) ? STORED_POINTS :
                                  TABLE_POINTS_DEF;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct {
      logic [VOLT_W-1:0] ocv;
      logic [SOC_W-1:0]  soc;
   } soc_entry_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [VOLT_W-1:0] req_ocv_mv;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [SOC_W-1:0]  rsp_soc_tenths;

   soc_entry_type pending_soc [$];
   int            error_count;
   int            quiet_cycles;
   bit            idling_on;
   bit            hold_results;

   ocv_to_soc_interpolator DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ocv_mv     (req_ocv_mv),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_soc_tenths (rsp_soc_tenths)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Piecewise linear lookup over the breakpoint table, quotient truncated.
   function automatic logic [SOC_W-1:0] expected_soc(input logic [VOLT_W-1:0] ocv);
      int unsigned seg;
      int unsigned lo_v;
      int unsigned hi_v;
      int unsigned lo_c;
      int unsigned hi_c;
      int unsigned soc;
      if (ocv < VOLT_BREAKS[0]) begin
         soc = 0;
      end else if (ocv >= VOLT_BREAKS[SPAN_POINTS-1]) begin
         soc = SOC_FULL;
      end else begin
         seg = 0;
         while (seg < SPAN_POINTS - 2 && VOLT_BREAKS[seg+1] <= ocv) seg++;
         lo_v = VOLT_BREAKS[seg];
         hi_v = VOLT_BREAKS[seg+1];
         lo_c = (seg * SOC_FULL) / (SPAN_POINTS - 1);
         hi_c = ((seg + 1) * SOC_FULL) / (SPAN_POINTS - 1);
         // an empty segment gives its lower charge point
         if (hi_v <= lo_v || ocv < lo_v)
            soc = lo_c;
         else
            soc = lo_c + ((ocv - lo_v) * (hi_c - lo_c)) / (hi_v - lo_v);
         if (soc > SOC_FULL) soc = SOC_FULL;
      end
      return soc[SOC_W-1:0];
   endfunction

   // Offer one voltage and hold it until the transfer, after an optional gap.
   task automatic send_voltage(input logic [VOLT_W-1:0] ocv);
      soc_entry_type entry;
      if (idling_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_ocv_mv <= ocv;
      do @(posedge clock); while (req_stall);
      entry.ocv = ocv;
      entry.soc = expected_soc(ocv);
      pending_soc.push_back(entry);
   endtask

   function automatic logic [VOLT_W-1:0] pick_voltage();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 65)
         return VOLT_W'($urandom_range(VOLT_BREAKS[0], VOLT_BREAKS[STORED_POINTS-1]));
      if (sel < 78) return VOLT_BREAKS[$urandom_range(0, STORED_POINTS - 1)];
      if (sel < 86) return VOLT_W'($urandom_range(VOLT_BREAKS[0] - 8, VOLT_BREAKS[0] + 8));
      if (sel < 94) return VOLT_W'($urandom_range(VOLT_BREAKS[STORED_POINTS-1] - 8,
                                                  VOLT_BREAKS[STORED_POINTS-1] + 8));
      return VOLT_W'($urandom_range(0, (1 << VOLT_W) - 1));
   endfunction

   task automatic test_table_edges();
      logic [VOLT_W-1:0] edge_volts [$];
      edge_volts = '{13'd0, 13'h1FFF, 13'h0AAA, 13'h1555,
                     VOLT_BREAKS[0] - 13'd1, VOLT_BREAKS[0], VOLT_BREAKS[0] + 13'd1,
                     VOLT_BREAKS[1] - 13'd1, VOLT_BREAKS[1],
                     VOLT_BREAKS[21], VOLT_BREAKS[21] + 13'd1, VOLT_BREAKS[21] + 13'd2,
                     VOLT_BREAKS[22], VOLT_BREAKS[100], VOLT_BREAKS[100] + 13'd1,
                     VOLT_BREAKS[199], VOLT_BREAKS[STORED_POINTS-1] - 13'd1,
                     VOLT_BREAKS[STORED_POINTS-1], VOLT_BREAKS[STORED_POINTS-1] + 13'd1,
                     13'd5000};
      foreach (edge_volts[k]) send_voltage(edge_volts[k]);
   endtask

   task automatic test_random_sweep(input int count);
      repeat (count) send_voltage(pick_voltage());
   endtask

   // Freeze the result side so the block fills up and stalls its input.
   task automatic test_output_backpressure();
      hold_results = 1'b1;
      repeat (20) send_voltage(pick_voltage());
      wait (!hold_results);
   endtask

   task automatic test_quiet_stream(input int count);
      idling_on = 1'b0;
      repeat (count) send_voltage(pick_voltage());
   endtask

   // Result side: random stall bursts, plus one long hold when asked.
   initial begin : result_side
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      soc_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_soc.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %0d",
                     $time, rsp_soc_tenths);
            error_count++;
         end else begin
            want = pending_soc.pop_front();
            if (rsp_soc_tenths !== want.soc) begin
               $display("%0t: soc_tenths for %0d mV: expected %0d, actual %0d",
                        $time, want.ocv, want.soc, rsp_soc_tenths);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_ocv_to_soc_interpolator: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      error_count  = 0;
      quiet_cycles = 0;
      idling_on    = 1'b1;
      hold_results = 1'b0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_ocv_mv <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_edges();
      test_random_sweep(480);
      test_output_backpressure();
      test_quiet_stream(130);

      req_valid <= 1'b0;
      while (pending_soc.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_ocv_to_soc_interpolator: clean");
      else
         $display("tb_ocv_to_soc_interpolator: errors");
      $finish;
   end

endmodule
